/* hw/rtl/cfo_pkg.sv */
`default_nettype none

package cfo_pkg;

	// Frame and NCO sizing
	localparam int SAMPLES_PER_SYMBOL = 288;
	localparam int FFT_POINTS_LOG2 = 8;
	localparam int FFT_POINTS = 1 << FFT_POINTS_LOG2;
	localparam int TABLE_PHASE_BITS = 12;
	localparam int SAMPLE_WIDTH = 16;

	localparam int PHASE_W = 32;
	localparam int EST_W = 16;
	localparam int THR_W = 15;
	localparam int SYM_W = 8;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_INDEX_W = 2;

	// Step is |estimate| * 2^16 / FFT_POINTS, an exact left shift
	localparam int STEP_SHIFT = 16 - FFT_POINTS_LOG2;

	// Longest frame is (255 + 2) symbols
	localparam int MAX_SYMBOLS = (1 << SYM_W) - 1;
	localparam int MAX_FRAME = (MAX_SYMBOLS + 2) * SAMPLES_PER_SYMBOL;
	localparam int CNT_W = $clog2(MAX_FRAME + 1);

	// Quarter-wave sine table
	localparam int QUARTER = 1 << (TABLE_PHASE_BITS - 2);
	localparam int QTR_W = TABLE_PHASE_BITS - 2;
	localparam int ADDR_W = TABLE_PHASE_BITS - 1;
	localparam int TAB_W = 16;
	localparam int TRIG_W = TAB_W + 1;
	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

	// Series divisors (2k)(2k+1) as reciprocals scaled by 2^SERIES_SHIFT, rounded up;
	// exact for every dividend the sine series produces (below 2^33)
	localparam int SERIES_SHIFT = 44;
	localparam logic [127:0] SERIES_ONE = 128'd1 << SERIES_SHIFT;
	localparam logic [63:0] SERIES_RECIP [16] = '{
		64'd0,
		64'((SERIES_ONE + 128'd5) / 128'd6),
		64'((SERIES_ONE + 128'd19) / 128'd20),
		64'((SERIES_ONE + 128'd41) / 128'd42),
		64'((SERIES_ONE + 128'd71) / 128'd72),
		64'((SERIES_ONE + 128'd109) / 128'd110),
		64'((SERIES_ONE + 128'd155) / 128'd156),
		64'((SERIES_ONE + 128'd209) / 128'd210),
		64'((SERIES_ONE + 128'd271) / 128'd272),
		64'((SERIES_ONE + 128'd341) / 128'd342),
		64'((SERIES_ONE + 128'd419) / 128'd420),
		64'((SERIES_ONE + 128'd505) / 128'd506),
		64'((SERIES_ONE + 128'd599) / 128'd600),
		64'((SERIES_ONE + 128'd701) / 128'd702),
		64'((SERIES_ONE + 128'd811) / 128'd812),
		64'((SERIES_ONE + 128'd929) / 128'd930)
	};

	// Register indexes on the configuration port
	localparam logic [CFG_INDEX_W-1:0] REG_CFO_ESTIMATE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CFO_THRESHOLD = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_IN_FRAME = 2'd2;

	localparam logic [THR_W-1:0] THRESHOLD_RESET = 15'd655;

	typedef struct packed {
		logic signed [EST_W-1:0] estimate;
		logic [THR_W-1:0] threshold;
		logic [SYM_W-1:0] symbols;
	} cfg_t;

	typedef struct packed {
		logic [TAB_W-1:0] sin_a;
		logic [TAB_W-1:0] sin_b;
		logic [1:0] quad;
		logic signed [SAMPLE_WIDTH-1:0] sample_i;
		logic signed [SAMPLE_WIDTH-1:0] sample_q;
		logic last;
	} mix_in_t;

	typedef logic [TAB_W-1:0] sin_rom_t [QUARTER+1];

	// Sine Taylor series in Q30, evaluated at elaboration only
	function automatic logic signed [63:0] series_q30(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] term;
		logic [127:0] scaled;
		logic signed [63:0] sum;
		x2 = (x * x) >> 30;
		term = x;
		sum = signed'(term);
		for (int k = 1; k < 16; k++) begin
			scaled = 128'((term * x2) >> 30) * SERIES_RECIP[k];
			term = scaled[SERIES_SHIFT +: 64];
			if ((k & 1) != 0)
				sum = sum - signed'(term);
			else
				sum = sum + signed'(term);
		end
		return sum;
	endfunction

	// Fill the quarter table, rounded to 2^-15, with +1.0 held as 32768
	function automatic sin_rom_t build_sin_rom();
		sin_rom_t rom;
		logic [63:0] x;
		logic signed [63:0] v;
		for (int k = 0; k <= QUARTER; k++) begin
			x = (64'(k) * PI_HALF_Q30 + 64'(QUARTER / 2)) >> QTR_W;
			v = series_q30(x);
			if (v < 0)
				v = 0;
			v = (v + 64'sd16384) >>> 15;
			if (v > 64'sd32768)
				v = 64'sd32768;
			rom[k] = v[TAB_W-1:0];
		end
		rom[0] = '0;
		rom[QUARTER] = TAB_W'(32768);
		return rom;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/cfo_nco.sv */
`default_nettype none

module cfo_nco
	import cfo_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic advance,
	output logic [TABLE_PHASE_BITS-1:0] table_phase
);

	logic [PHASE_W-1:0] phase_q;
	logic [CNT_W-1:0] count_q;

	logic [EST_W:0] est_ext;
	logic [EST_W:0] mag;
	logic [PHASE_W-1:0] mag_step;
	logic [PHASE_W-1:0] step;
	logic [PHASE_W-1:0] phase_next;
	logic [CNT_W-1:0] frame_len;
	logic [CNT_W-1:0] count_next;

	// Step from the offset estimate, zero inside the dead zone
	always_comb begin
		est_ext = {cfg.estimate[EST_W-1], cfg.estimate};
		mag = cfg.estimate[EST_W-1] ? ((EST_W+1)'(0) - est_ext) : est_ext;
		mag_step = PHASE_W'(mag) << STEP_SHIFT;
		if (mag > (EST_W+1)'(cfg.threshold))
			step = cfg.estimate[EST_W-1] ? (PHASE_W'(0) - mag_step) : mag_step;
		else
			step = '0;
	end

	assign phase_next = phase_q - step;
	assign table_phase = phase_next[PHASE_W-1 -: TABLE_PHASE_BITS];

	// Frame length: data symbols plus two
	assign frame_len = (CNT_W'(cfg.symbols) + CNT_W'(2)) * CNT_W'(SAMPLES_PER_SYMBOL);
	assign count_next = count_q + CNT_W'(1);

	// Advance phase per transaction, restart at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			count_q <= '0;
		end else if (advance) begin
			if (count_next >= frame_len) begin
				phase_q <= '0;
				count_q <= '0;
			end else begin
				phase_q <= phase_next;
				count_q <= count_next;
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/cfo_sin_rom.sv */
`default_nettype none

module cfo_sin_rom
	import cfo_pkg::*;
(
	input  wire logic clk,
	input  wire logic en,
	input  wire logic [ADDR_W-1:0] addr_a,
	input  wire logic [ADDR_W-1:0] addr_b,
	output logic [TAB_W-1:0] data_a,
	output logic [TAB_W-1:0] data_b
);

	localparam sin_rom_t SIN_ROM = build_sin_rom();

	// Two registered read ports
	always_ff @(posedge clk) begin
		if (en) begin
			data_a <= SIN_ROM[addr_a];
			data_b <= SIN_ROM[addr_b];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/cfo_mixer.sv */
`default_nettype none

module cfo_mixer
	import cfo_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire mix_in_t mix_in,
	input  wire logic mix_valid,
	output logic mix_take,
	output logic signed [SAMPLE_WIDTH-1:0] rotated_i,
	output logic signed [SAMPLE_WIDTH-1:0] rotated_q,
	output logic last_out,
	output logic rotated_valid,
	input  wire logic rotated_stall
);

	localparam int PROD_W = SAMPLE_WIDTH + TRIG_W;
	localparam int SUM_W = PROD_W + 1;
	localparam int SH_W = SUM_W - 15;
	localparam logic signed [SH_W-1:0] SAT_HI = SH_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
	localparam logic signed [SH_W-1:0] SAT_LO = -SAT_HI - SH_W'(1);

	logic signed [TRIG_W-1:0] sin_a;
	logic signed [TRIG_W-1:0] sin_b;
	logic signed [TRIG_W-1:0] sn;
	logic signed [TRIG_W-1:0] cs;
	logic signed [PROD_W-1:0] prod_ic;
	logic signed [PROD_W-1:0] prod_qs;
	logic signed [PROD_W-1:0] prod_qc;
	logic signed [PROD_W-1:0] prod_is;

	logic signed [PROD_W-1:0] ic_s3;
	logic signed [PROD_W-1:0] qs_s3;
	logic signed [PROD_W-1:0] qc_s3;
	logic signed [PROD_W-1:0] is_s3;
	logic last_s3;
	logic valid_s3;

	logic signed [SUM_W-1:0] sum_i;
	logic signed [SUM_W-1:0] sum_q;

	logic signed [SAMPLE_WIDTH-1:0] rot_i_s4;
	logic signed [SAMPLE_WIDTH-1:0] rot_q_s4;
	logic last_s4;
	logic valid_s4;

	logic en_s3;
	logic en_s4;

	// Floor to Q1.15 and clamp to the sample range
	function automatic logic signed [SAMPLE_WIDTH-1:0] floor_sat(input logic signed [SUM_W-1:0] s);
		logic signed [SH_W-1:0] f;
		f = s[SUM_W-1:15];
		if (f > SAT_HI)
			f = SAT_HI;
		else if (f < SAT_LO)
			f = SAT_LO;
		return f[SAMPLE_WIDTH-1:0];
	endfunction

	assign en_s4 = !valid_s4 || !rotated_stall;
	assign en_s3 = !valid_s3 || en_s4;
	assign mix_take = en_s3;

	// Unfold quadrant into signed sine and cosine
	always_comb begin
		sin_a = signed'({1'b0, mix_in.sin_a});
		sin_b = signed'({1'b0, mix_in.sin_b});
		unique case (mix_in.quad)
			2'd0: begin
				sn = sin_a;
				cs = sin_b;
			end
			2'd1: begin
				sn = sin_b;
				cs = -sin_a;
			end
			2'd2: begin
				sn = -sin_a;
				cs = -sin_b;
			end
			default: begin
				sn = -sin_b;
				cs = sin_a;
			end
		endcase
		prod_ic = PROD_W'(mix_in.sample_i) * PROD_W'(cs);
		prod_qs = PROD_W'(mix_in.sample_q) * PROD_W'(sn);
		prod_qc = PROD_W'(mix_in.sample_q) * PROD_W'(cs);
		prod_is = PROD_W'(mix_in.sample_i) * PROD_W'(sn);
	end

	// Product stage
	always_ff @(posedge clk) begin
		if (en_s3) begin
			ic_s3 <= prod_ic;
			qs_s3 <= prod_qs;
			qc_s3 <= prod_qc;
			is_s3 <= prod_is;
			last_s3 <= mix_in.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else if (en_s3)
			valid_s3 <= mix_valid;
	end

	// Sum, floor and saturate
	assign sum_i = SUM_W'(ic_s3) + SUM_W'(qs_s3);
	assign sum_q = SUM_W'(qc_s3) - SUM_W'(is_s3);

	always_ff @(posedge clk) begin
		if (en_s4) begin
			rot_i_s4 <= floor_sat(sum_i);
			rot_q_s4 <= floor_sat(sum_q);
			last_s4 <= last_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s4 <= 1'b0;
		else if (en_s4)
			valid_s4 <= valid_s3;
	end

	assign rotated_i = rot_i_s4;
	assign rotated_q = rot_q_s4;
	assign last_out = last_s4;
	assign rotated_valid = valid_s4;

endmodule

`default_nettype wire

/* hw/rtl/cfo_phase_rotator_unit.sv */
// Pipeline: four register stages, the first loaded at the accepting edge, so a result
// is presented from the fourth stage register after its sample transaction is accepted.
// Throughput: one sample per clock while rotated_stall is low; phase update, ROM read,
// products and saturating sum each take one register stage, so samples follow unbroken.
// Reset (arst_n low, asynchronous): pipeline empty, phase and sample counter zero,
// cfo_estimate 0, cfo_threshold 655, symbols_in_frame 0. No clearing pass.
`default_nettype none

module cfo_phase_rotator_unit
	import cfo_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic sample_valid,
	output logic sample_stall,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample_i,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample_q,
	input  wire logic last_in,
	output logic rotated_valid,
	input  wire logic rotated_stall,
	output logic signed [SAMPLE_WIDTH-1:0] rotated_i,
	output logic signed [SAMPLE_WIDTH-1:0] rotated_q,
	output logic last_out
);

	cfg_t cfg_q;

	logic advance;
	logic [TABLE_PHASE_BITS-1:0] table_phase;

	logic valid_s1;
	logic [TABLE_PHASE_BITS-1:0] idx_s1;
	logic signed [SAMPLE_WIDTH-1:0] i_s1;
	logic signed [SAMPLE_WIDTH-1:0] q_s1;
	logic last_s1;

	logic valid_s2;
	logic [1:0] quad_s2;
	logic signed [SAMPLE_WIDTH-1:0] i_s2;
	logic signed [SAMPLE_WIDTH-1:0] q_s2;
	logic last_s2;

	logic [QTR_W-1:0] k_s1;
	logic [ADDR_W-1:0] addr_a;
	logic [ADDR_W-1:0] addr_b;
	logic [TAB_W-1:0] sin_a;
	logic [TAB_W-1:0] sin_b;

	mix_in_t mix_in;
	logic mix_take;
	logic en_s1;
	logic en_s2;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.estimate <= '0;
			cfg_q.threshold <= THRESHOLD_RESET;
			cfg_q.symbols <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CFO_ESTIMATE: cfg_q.estimate <= signed'(cfg_data[EST_W-1:0]);
				REG_CFO_THRESHOLD: cfg_q.threshold <= cfg_data[THR_W-1:0];
				REG_SYMBOLS_IN_FRAME: cfg_q.symbols <= cfg_data[SYM_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage enables: a stage loads when empty or when its successor moves
	assign en_s2 = !valid_s2 || mix_take;
	assign en_s1 = !valid_s1 || en_s2;
	assign sample_stall = !en_s1;
	assign advance = sample_valid && en_s1;

	cfo_nco u_nco (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.advance(advance),
		.table_phase(table_phase)
	);

	// Stage 1: capture sample and table phase
	always_ff @(posedge clk) begin
		if (en_s1) begin
			idx_s1 <= table_phase;
			i_s1 <= sample_i;
			q_s1 <= sample_q;
			last_s1 <= last_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (en_s1)
			valid_s1 <= sample_valid;
	end

	// Quarter-wave addresses for sine and its mirror
	assign k_s1 = idx_s1[QTR_W-1:0];
	assign addr_a = ADDR_W'(k_s1);
	assign addr_b = ADDR_W'(QUARTER) - ADDR_W'(k_s1);

	cfo_sin_rom u_sin_rom (
		.clk(clk),
		.en(en_s2),
		.addr_a(addr_a),
		.addr_b(addr_b),
		.data_a(sin_a),
		.data_b(sin_b)
	);

	// Stage 2: hold sample beside the ROM output
	always_ff @(posedge clk) begin
		if (en_s2) begin
			quad_s2 <= idx_s1[TABLE_PHASE_BITS-1 -: 2];
			i_s2 <= i_s1;
			q_s2 <= q_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (en_s2)
			valid_s2 <= valid_s1;
	end

	always_comb begin
		mix_in.sin_a = sin_a;
		mix_in.sin_b = sin_b;
		mix_in.quad = quad_s2;
		mix_in.sample_i = i_s2;
		mix_in.sample_q = q_s2;
		mix_in.last = last_s2;
	end

	cfo_mixer u_mixer (
		.clk(clk),
		.arst_n(arst_n),
		.mix_in(mix_in),
		.mix_valid(valid_s2),
		.mix_take(mix_take),
		.rotated_i(rotated_i),
		.rotated_q(rotated_q),
		.last_out(last_out),
		.rotated_valid(rotated_valid),
		.rotated_stall(rotated_stall)
	);

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import cfo_pkg::*;

	// Index 3 has no register behind it
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_ITEMS = 60;
	// Phases before this one use longer frames; from here on the frame is the shortest,
	// switched in while the count is still below it
	localparam int SHORT_FRAME_PHASE = 4;
	localparam logic signed [SAMPLE_WIDTH-1:0] LEVEL_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] LEVEL_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		logic [CFG_INDEX_W-1:0] index;
		logic [CFG_DATA_W-1:0] data;
		logic signed [SAMPLE_WIDTH-1:0] i;
		logic signed [SAMPLE_WIDTH-1:0] q;
		logic last;
		logic passthru;
	} row_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] i;
		logic signed [SAMPLE_WIDTH-1:0] q;
		logic last;
	} rotated_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	logic signed [SAMPLE_WIDTH-1:0] sample_i = '0;
	logic signed [SAMPLE_WIDTH-1:0] sample_q = '0;
	logic last_in = 1'b0;
	logic rotated_valid;
	logic rotated_stall = 1'b0;
	logic signed [SAMPLE_WIDTH-1:0] rotated_i;
	logic signed [SAMPLE_WIDTH-1:0] rotated_q;
	logic last_out;

	// Mixer model state
	int unsigned sine_quarter [QUARTER+1];
	logic [PHASE_W-1:0] nco_phase = '0;
	int unsigned frame_count = 0;
	logic signed [EST_W-1:0] cfo_est = '0;
	logic [THR_W-1:0] cfo_thr = THRESHOLD_RESET;
	logic [SYM_W-1:0] frame_symbols = '0;

	rotated_t rotated_expected [$];
	rotated_t oldest;
	int error_count = 0;
	int cycle_count = 0;
	int burst_left = 0;
	int rx_hold = 0;
	int rx_flow = 0;

	cfo_phase_rotator_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample_i(sample_i),
		.sample_q(sample_q),
		.last_in(last_in),
		.rotated_valid(rotated_valid),
		.rotated_stall(rotated_stall),
		.rotated_i(rotated_i),
		.rotated_q(rotated_q),
		.last_out(last_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Drop the product to Q1.15 by flooring, then clip to the sample range
	function automatic logic signed [SAMPLE_WIDTH-1:0] floor_sat(input longint acc);
		longint r;
		r = acc >>> 15;
		if (r > longint'(LEVEL_MAX))
			r = longint'(LEVEL_MAX);
		else if (r < longint'(LEVEL_MIN))
			r = longint'(LEVEL_MIN);
		return SAMPLE_WIDTH'(r);
	endfunction

	// Advance the NCO by one sample and derotate it; updates the model state
	function automatic rotated_t rotate_sample(input logic signed [SAMPLE_WIDTH-1:0] si,
			input logic signed [SAMPLE_WIDTH-1:0] sq, input logic last);
		rotated_t res;
		longint mag;
		longint sn;
		longint cs;
		logic [PHASE_W-1:0] step;
		logic [TABLE_PHASE_BITS-1:0] idx;
		int k;
		step = '0;
		mag = (cfo_est < 0) ? -longint'(cfo_est) : longint'(cfo_est);
		if (mag > longint'(cfo_thr)) begin
			step = PHASE_W'((mag << 16) / FFT_POINTS);
			if (cfo_est < 0)
				step = -step;
		end
		nco_phase = nco_phase - step;
		idx = nco_phase[PHASE_W-1 -: TABLE_PHASE_BITS];
		k = int'(idx[QTR_W-1:0]);
		case (idx[TABLE_PHASE_BITS-1 -: 2])
			2'd0: begin
				sn = sine_quarter[k];
				cs = sine_quarter[QUARTER - k];
			end
			2'd1: begin
				sn = sine_quarter[QUARTER - k];
				cs = -longint'(sine_quarter[k]);
			end
			2'd2: begin
				sn = -longint'(sine_quarter[k]);
				cs = -longint'(sine_quarter[QUARTER - k]);
			end
			default: begin
				sn = -longint'(sine_quarter[QUARTER - k]);
				cs = sine_quarter[k];
			end
		endcase
		res.i = floor_sat(longint'(si) * cs + longint'(sq) * sn);
		res.q = floor_sat(longint'(sq) * cs - longint'(si) * sn);
		res.last = last;
		// Close the frame once the count reaches the current frame length
		frame_count++;
		if (frame_count >= (int'(frame_symbols) + 2) * SAMPLES_PER_SYMBOL) begin
			frame_count = 0;
			nco_phase = '0;
		end
		return res;
	endfunction

	function automatic row_t sample_row(input logic signed [SAMPLE_WIDTH-1:0] si,
			input logic signed [SAMPLE_WIDTH-1:0] sq, input logic last, input logic passthru);
		row_t r;
		r = '0;
		r.kind = ROW_SAMPLE;
		r.i = si;
		r.q = sq;
		r.last = last;
		r.passthru = passthru;
		return r;
	endfunction

	function automatic row_t write_row(input logic [CFG_INDEX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		row_t r;
		r = '0;
		r.kind = ROW_WRITE;
		r.index = index;
		r.data = data;
		return r;
	endfunction

	// Mostly back to back, some short gaps, a few long ones, and bursts with none
	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			burst_left = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [SAMPLE_WIDTH-1:0] random_level();
		case ($urandom_range(0, 7))
			0: return LEVEL_MAX;
			1: return LEVEL_MIN;
			2: return SAMPLE_WIDTH'($urandom_range(0, 8)) - SAMPLE_WIDTH'(4);
			default: return SAMPLE_WIDTH'($urandom);
		endcase
	endfunction

	// Present one sample, hold it until taken, then log what should come out
	task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] si,
			input logic signed [SAMPLE_WIDTH-1:0] sq, input logic last, input logic passthru);
		rotated_t want;
		@(negedge clk);
		sample_valid <= 1'b1;
		sample_i <= si;
		sample_q <= sq;
		last_in <= last;
		do
			@(posedge clk);
		while (sample_stall);
		want = rotate_sample(si, sq, last);
		if (passthru) begin
			want.i = si;
			want.q = sq;
		end
		rotated_expected.push_back(want);
	endtask

	task automatic hold_off(input int cycles);
		@(negedge clk);
		sample_valid <= 1'b0;
		repeat (cycles - 1)
			@(negedge clk);
	endtask

	// Stop sending and wait for every outstanding transaction to come back
	task automatic drain();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (rotated_expected.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (index)
			REG_CFO_ESTIMATE: cfo_est = data[EST_W-1:0];
			REG_CFO_THRESHOLD: cfo_thr = data[THR_W-1:0];
			REG_SYMBOLS_IN_FRAME: frame_symbols = data[SYM_W-1:0];
			default: ;
		endcase
	endtask

	// Output side: random stall pattern, changed at the falling edge
	initial begin
		forever begin
			@(negedge clk);
			if (rx_hold == 0 && rx_flow == 0) begin
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4, 5, 6, 7, 8, 9: rx_flow = $urandom_range(1, 8);
					10, 11: rx_flow = $urandom_range(50, 200);
					12, 13, 14, 15, 16, 17: rx_hold = $urandom_range(1, 3);
					default: rx_hold = $urandom_range(10, 40);
				endcase
			end
			if (rx_hold > 0) begin
				rotated_stall <= 1'b1;
				rx_hold--;
			end else begin
				rotated_stall <= 1'b0;
				rx_flow--;
			end
		end
	end

	// Compare each accepted output transaction with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && rotated_valid && !rotated_stall) begin
			if (rotated_expected.size() == 0) begin
				$display("%0t: unexpected output i=%0d q=%0d last=%0b",
					$time, rotated_i, rotated_q, last_out);
				error_count++;
			end else begin
				oldest = rotated_expected.pop_front();
				if (rotated_i !== oldest.i) begin
					$display("%0t: rotated_i mismatch: expected %0d, got %0d",
						$time, oldest.i, rotated_i);
					error_count++;
				end
				if (rotated_q !== oldest.q) begin
					$display("%0t: rotated_q mismatch: expected %0d, got %0d",
						$time, oldest.q, rotated_q);
					error_count++;
				end
				if (last_out !== oldest.last) begin
					$display("%0t: last_out mismatch: expected %0b, got %0b",
						$time, oldest.last, last_out);
					error_count++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		logic [63:0] ang;
		logic [63:0] ang_sq;
		logic [63:0] term;
		longint acc;
		row_t plan [$];
		row_t row;
		logic [CFG_DATA_W-1:0] est_word;
		int thr_val;
		int sym_val;
		int gap;

		// Quarter-wave sine in Q1.15 from a Q30 Taylor series
		for (int n = 0; n <= QUARTER; n++) begin
			ang = (64'(n) * PI_HALF_Q30 + 64'(QUARTER / 2)) / 64'(QUARTER);
			ang_sq = (ang * ang) >> 30;
			term = ang;
			acc = longint'(ang);
			for (int t = 1; t < 16; t++) begin
				term = ((term * ang_sq) >> 30) / (64'(2 * t) * 64'(2 * t + 1));
				if (t % 2 == 1)
					acc = acc - longint'(term);
				else
					acc = acc + longint'(term);
			end
			if (acc < 0)
				acc = 0;
			acc = (acc + 16384) >>> 15;
			if (acc > 32768)
				acc = 32768;
			sine_quarter[n] = int'(acc);
		end
		sine_quarter[0] = 0;
		sine_quarter[QUARTER] = 32768;

		repeat (5)
			@(negedge clk);
		arst_n <= 1'b1;

		// Directed: zero phase passes samples through untouched, dead zone edges,
		// smallest step, largest steps both ways, largest threshold, spare index
		plan.push_back(sample_row(16'h0000, 16'h0000, 1'b0, 1'b1));
		plan.push_back(sample_row(LEVEL_MAX, LEVEL_MIN, 1'b1, 1'b1));
		plan.push_back(sample_row(LEVEL_MIN, LEVEL_MAX, 1'b0, 1'b1));
		plan.push_back(sample_row(16'hFFFF, 16'h0001, 1'b1, 1'b1));
		plan.push_back(write_row(REG_CFO_ESTIMATE, 16'd655));
		plan.push_back(sample_row(16'h3039, 16'hCFC7, 1'b0, 1'b1));
		plan.push_back(write_row(REG_CFO_ESTIMATE, 16'hFD71));
		plan.push_back(sample_row(LEVEL_MIN, LEVEL_MIN, 1'b1, 1'b1));
		plan.push_back(write_row(REG_CFO_THRESHOLD, 16'h0000));
		plan.push_back(write_row(REG_CFO_ESTIMATE, 16'h0001));
		plan.push_back(sample_row(LEVEL_MAX, LEVEL_MAX, 1'b0, 1'b0));
		plan.push_back(sample_row(LEVEL_MIN, LEVEL_MIN, 1'b1, 1'b0));
		plan.push_back(write_row(REG_CFO_ESTIMATE, 16'h7FFF));
		plan.push_back(sample_row(LEVEL_MAX, 16'h0000, 1'b0, 1'b0));
		plan.push_back(sample_row(16'h0000, LEVEL_MAX, 1'b1, 1'b0));
		plan.push_back(sample_row(LEVEL_MIN, LEVEL_MIN, 1'b0, 1'b0));
		plan.push_back(write_row(REG_CFO_ESTIMATE, 16'h8000));
		plan.push_back(sample_row(16'h5A5A, 16'hA5A5, 1'b1, 1'b0));
		plan.push_back(sample_row(LEVEL_MIN, LEVEL_MAX, 1'b0, 1'b0));
		plan.push_back(write_row(REG_CFO_THRESHOLD, 16'hFFFF));
		plan.push_back(sample_row(LEVEL_MAX, LEVEL_MIN, 1'b1, 1'b0));
		plan.push_back(write_row(REG_SYMBOLS_IN_FRAME, 16'hFFFF));
		plan.push_back(write_row(REG_SPARE, 16'hFFFF));
		plan.push_back(write_row(REG_CFO_ESTIMATE, 16'h4000));
		plan.push_back(sample_row(16'h1234, 16'hEDCC, 1'b0, 1'b0));

		foreach (plan[n]) begin
			row = plan[n];
			if (row.kind == ROW_WRITE) begin
				drain();
				write_reg(row.index, row.data);
			end else begin
				send_sample(row.i, row.q, row.last, row.passthru);
				gap = pick_gap();
				if (gap > 0)
					hold_off(gap);
			end
		end

		// Random phases: longer frames first, then the shortest frame while the count
		// is still below it, so the count runs into the frame end and restarts the phase
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain();
			if (ph == 0 || $urandom_range(0, 1) == 1) begin
				case ($urandom_range(0, 7))
					0: thr_val = 0;
					1: thr_val = 32767;
					2: thr_val = 655;
					default: thr_val = $urandom_range(0, 4000);
				endcase
				write_reg(REG_CFO_THRESHOLD, {1'($urandom), THR_W'(thr_val)});
			end
			if (ph == 0)
				sym_val = 255;
			else if (ph >= SHORT_FRAME_PHASE)
				sym_val = 0;
			else if ($urandom_range(0, 3) == 0)
				sym_val = $urandom_range(1, 255);
			else
				sym_val = $urandom_range(1, 2);
			write_reg(REG_SYMBOLS_IN_FRAME, {8'($urandom), SYM_W'(sym_val)});
			case ($urandom_range(0, 9))
				0: est_word = 16'h8000;
				1: est_word = 16'h7FFF;
				2: begin
					est_word = CFG_DATA_W'(int'(cfo_thr) + $urandom_range(0, 1));
					if ($urandom_range(0, 1) == 1)
						est_word = -est_word;
				end
				3: est_word = CFG_DATA_W'($urandom_range(0, 700));
				default: est_word = CFG_DATA_W'($urandom);
			endcase
			write_reg(REG_CFO_ESTIMATE, est_word);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_sample(random_level(), random_level(), $urandom_range(0, 7) == 0, 1'b0);
				gap = pick_gap();
				if (gap > 0)
					hold_off(gap);
			end
		end

		drain();
		repeat (DRAIN_CYCLES)
			@(negedge clk);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
